// ----- hdl/fpa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package fpa_pkg;

    // Operation codes carried in the mode field.
    localparam logic [3:0] MODE_ADD     = 4'd0;
    localparam logic [3:0] MODE_SUB     = 4'd1;
    localparam logic [3:0] MODE_MUL     = 4'd2;
    localparam logic [3:0] MODE_DIV     = 4'd3;
    localparam logic [3:0] MODE_MIN     = 4'd4;
    localparam logic [3:0] MODE_MAX     = 4'd5;
    localparam logic [3:0] MODE_INC     = 4'd6;
    localparam logic [3:0] MODE_DEC     = 4'd7;
    localparam logic [3:0] MODE_TO_FIX  = 4'd8;
    localparam logic [3:0] MODE_TO_INT  = 4'd9;

    localparam int WORD_W = 32;

    // Input word.
    typedef struct packed {
        logic [3:0]         mode;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
    } t_in_word;

    // Result word.
    typedef struct packed {
        logic signed [31:0] result_value;
        logic               a_less_b;
        logic               a_equal_b;
        logic               a_greater_b;
        logic               divide_by_zero;
    } t_out_word;

endpackage

`default_nettype wire

// ----- hdl/fpa_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface fpa_in_if
    import fpa_pkg::*;
();
    logic     valid;
    logic     ready;
    t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface fpa_out_if
    import fpa_pkg::*;
();
    logic      valid;
    logic      ready;
    t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hdl/fixed_point_q24_8_alu.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Q24.8 fixed-point ALU (FRACTION_BITS fraction bits, 32-bit raw words).
// Input channel i_in carries mode and two raw operands; output channel o_out
// carries the result word with signed compare flags and a divide-by-zero flag.
// Every accepted word passes through one input stage, one multiply stage, a
// chain of one division cell per dividend bit, and the output register, which
// also applies the quotient sign.
// While the receiver does not stall, the chain accepts one word per cycle, so throughput is one word per cycle.
// All operations travel the same chain, so results leave in order.
// When the receiver stalls, the whole chain holds and i_in.ready drops;
// the output register keeps its word until taken. A synchronous active-low
// reset clears all valid bits and holds i_in.ready low while it is asserted;
// payload registers are not reset.
module fixed_point_q24_8_alu
    import fpa_pkg::*;
#(
    parameter int FRACTION_BITS = 8
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    fpa_in_if.sink    i_in,
    fpa_out_if.source o_out
);

    localparam int DVD_W  = WORD_W + FRACTION_BITS;
    localparam int NCELL  = DVD_W;
    // Side data: mode, a, b, quotient sign, partial result, compare flags.
    localparam int SIDE_W = 4 + WORD_W + WORD_W + 1 + WORD_W + 3;

    typedef struct packed {
        logic [3:0]        mode;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic              qneg;
        logic [WORD_W-1:0] part;
        logic              lt;
        logic              eq;
        logic              gt;
    } t_side;

    logic en;
    logic [NCELL+2:0] r_vld;

    assign en         = !o_out.valid || o_out.ready;
    assign i_in.ready = en && i_rst_n;

    // Input stage.
    t_in_word r_in;
    always_ff @(posedge i_clk) begin
        if (en) r_in <= i_in.data;
    end

    // Multiply, compare and simple ops; prepare division magnitudes.
    logic signed [2*WORD_W-1:0] w_prod;
    logic [2*WORD_W-1:0]        w_psh;
    logic [WORD_W-1:0]          w_part;
    logic [WORD_W-1:0]          w_ma;
    logic [WORD_W-1:0]          w_mb;
    logic                       w_lt;
    logic                       w_eq;
    logic                       w_gt;
    always_comb begin
        w_prod = r_in.operand_a * r_in.operand_b;
        w_psh  = w_prod >>> FRACTION_BITS;
        w_lt   = r_in.operand_a < r_in.operand_b;
        w_eq   = r_in.operand_a == r_in.operand_b;
        w_gt   = r_in.operand_a > r_in.operand_b;
        w_ma   = r_in.operand_a[WORD_W-1] ? -r_in.operand_a : r_in.operand_a;
        w_mb   = r_in.operand_b[WORD_W-1] ? -r_in.operand_b : r_in.operand_b;
        case (r_in.mode)
            MODE_ADD:    w_part = r_in.operand_a + r_in.operand_b;
            MODE_SUB:    w_part = r_in.operand_a - r_in.operand_b;
            MODE_MUL:    w_part = w_psh[WORD_W-1:0];
            MODE_MIN:    w_part = w_lt ? r_in.operand_a : r_in.operand_b;
            MODE_MAX:    w_part = w_gt ? r_in.operand_a : r_in.operand_b;
            MODE_INC:    w_part = r_in.operand_a + 32'sd1;
            MODE_DEC:    w_part = r_in.operand_a - 32'sd1;
            MODE_TO_FIX: w_part = r_in.operand_a <<< FRACTION_BITS;
            MODE_TO_INT: w_part = r_in.operand_a >>> FRACTION_BITS;
            default:     w_part = '0;
        endcase
    end

    t_side             r_s0;
    logic [DVD_W-1:0]  r_dvd0;
    logic [WORD_W-1:0] r_dsr0;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0.mode <= r_in.mode;
            r_s0.a    <= r_in.operand_a;
            r_s0.b    <= r_in.operand_b;
            r_s0.qneg <= r_in.operand_a[WORD_W-1] ^ r_in.operand_b[WORD_W-1];
            r_s0.part <= w_part;
            r_s0.lt   <= w_lt;
            r_s0.eq   <= w_eq;
            r_s0.gt   <= w_gt;
            r_dvd0    <= {w_ma, {FRACTION_BITS{1'b0}}};
            r_dsr0    <= w_mb;
        end
    end

    // Chain of division cells.
    logic [WORD_W:0]   c_rem  [0:NCELL];
    logic [DVD_W-1:0]  c_dvd  [0:NCELL];
    logic [WORD_W-1:0] c_dsr  [0:NCELL];
    logic [SIDE_W-1:0] c_side [0:NCELL];

    assign c_rem[0]  = '0;
    assign c_dvd[0]  = r_dvd0;
    assign c_dsr[0]  = r_dsr0;
    assign c_side[0] = r_s0;

    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        fpa_div_cell #(.DVD_W(DVD_W), .SIDE_W(SIDE_W)) u_cell (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_rem  (c_rem[g]),
            .i_dvd  (c_dvd[g]),
            .i_dsr  (c_dsr[g]),
            .i_side (c_side[g]),
            .o_rem  (c_rem[g+1]),
            .o_dvd  (c_dvd[g+1]),
            .o_dsr  (c_dsr[g+1]),
            .o_side (c_side[g+1])
        );
    end

    // Sign fix and result selection into the output register.
    t_side             w_se;
    logic [WORD_W-1:0] w_q;
    t_out_word         r_out;
    always_comb begin
        w_se = c_side[NCELL];
        w_q  = w_se.qneg ? -c_dvd[NCELL][WORD_W-1:0] : c_dvd[NCELL][WORD_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.a_less_b       <= w_se.lt;
            r_out.a_equal_b      <= w_se.eq;
            r_out.a_greater_b    <= w_se.gt;
            r_out.divide_by_zero <= 1'b0;
            r_out.result_value   <= w_se.part;
            if (w_se.mode == MODE_DIV) begin
                if (w_se.b == '0) begin
                    r_out.divide_by_zero <= 1'b1;
                    r_out.result_value   <= '0;
                end else begin
                    r_out.result_value <= w_q;
                end
            end
        end
    end

    // Valid bits travel alongside the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NCELL+1:0], i_in.valid};
        end
    end

    assign o_out.valid = r_vld[NCELL+2];
    assign o_out.data  = r_out;

endmodule

`default_nettype wire

// ----- hdl/fpa_div_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

// One restoring-division step on magnitudes, registered. The quotient bits
// fill in from the bottom while the dividend bits shift out of the top.
module fpa_div_cell
    import fpa_pkg::*;
#(
    parameter int DVD_W = 40,
    parameter int SIDE_W = 40
) (
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic [WORD_W:0]   i_rem,
    input  wire logic [DVD_W-1:0]  i_dvd,
    input  wire logic [WORD_W-1:0] i_dsr,
    input  wire logic [SIDE_W-1:0] i_side,
    output      logic [WORD_W:0]   o_rem,
    output      logic [DVD_W-1:0]  o_dvd,
    output      logic [WORD_W-1:0] o_dsr,
    output      logic [SIDE_W-1:0] o_side
);

    logic [WORD_W:0]   n_rem;
    logic [WORD_W+1:0] w_trial;
    logic [WORD_W+1:0] w_shift;
    logic [DVD_W-1:0]  n_dvd;

    // Shift one dividend bit into the remainder and try the subtraction.
    always_comb begin
        w_shift = {i_rem, i_dvd[DVD_W-1]};
        w_trial = w_shift - {2'b00, i_dsr};
        if (!w_trial[WORD_W+1]) begin
            n_rem = w_trial[WORD_W:0];
            n_dvd = {i_dvd[DVD_W-2:0], 1'b1};
        end else begin
            n_rem = w_shift[WORD_W:0];
            n_dvd = {i_dvd[DVD_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem  <= n_rem;
            o_dvd  <= n_dvd;
            o_dsr  <= i_dsr;
            o_side <= i_side;
        end
    end

endmodule

`default_nettype wire
